[hdl/mlhe_pkg.sv]
// Package for the weighted Huber error block of the mobility law.
// Holds the transaction structs, the sequencer states and the register indexes.
// No dependencies.
`default_nettype none

package mlhe_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_MOBILITY_BURGERS = 3'd0;
   localparam logic [2:0] CSR_ALPHA_COEFF      = 3'd1;
   localparam logic [2:0] CSR_BETA_COEFF       = 3'd2;
   localparam logic [2:0] CSR_SHEAR_BURGERS    = 3'd3;
   localparam logic [2:0] CSR_HUBER_THRESHOLD  = 3'd4;

   // Default Huber threshold, integer part (8.0)
   localparam int unsigned HUBER_DEFAULT_INT = 8;

   // Saturation value of the running sum
   localparam logic [62:0] SUM_MAX = {63{1'b1}};

   // First trial bit of the restoring square root
   localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
   localparam int unsigned SQRT_STEPS    = 32;

   // Input transaction
   typedef struct packed {
      logic signed [31:0] stress;
      logic        [31:0] density;
      logic signed [31:0] measured_velocity;
      logic        [15:0] sample_weight;
      logic               last_sample;
   } req_data_type;

   // Result transaction
   typedef struct packed {
      logic signed [31:0] fitted_velocity;
      logic        [62:0] error_sum;
      logic               sum_final;
      logic               sum_saturated;
   } rsp_data_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_AA,
      ST_LD_RAD,
      ST_MUL_RAD,
      ST_SH_RAD,
      ST_MUL_BB,
      ST_ADD_RAD,
      ST_SQRT,
      ST_LD_SH,
      ST_MUL_SH,
      ST_DIFF,
      ST_LD_V,
      ST_MUL_V,
      ST_FIT,
      ST_RES,
      ST_MUL_L,
      ST_LD_W,
      ST_MUL_W,
      ST_ACC
   } state_type;

   // Datapath enables decoded from the state
   typedef struct packed {
      logic mul_en;
      logic sqrt_en;
      logic busy;
   } ctrl_type;

   // Magnitude of a signed 32-bit value as unsigned 32 bits
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/mobility_law_huber_error_top.sv]
// Weighted Huber error of a mobility law fit, one sample per transaction.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries one sample: stress,
//    dislocation density, measured velocity, Q8.8 weight and a last-sample mark.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns one transaction per
//    sample: the saturated fitted velocity, the running weighted Huber sum, the
//    last-sample mark and a sticky saturation flag. The sum clears after the
//    transaction of a last sample.
//  - csr channel (csr_valid / csr_ready / csr_index / csr_wdata) writes the five
//    coefficient registers; write only while the block is idle. Unknown indexes
//    are dropped.
// Timing: a sample is processed by a sequencer around one shared 32x32
// multiplier (every product is built from the low and then the high half of the
// wide operand) and a 32-step restoring square root. The next sample is taken
// only once the sequencer is back in idle; req_stall is high while a sample is
// in work.
// The result register decouples the sides: a stalled result holds, and the
// sequencer waits in its last step only if a new result is ready before the old
// one is taken.
// Reset (synchronous, active high) restores the register defaults and clears
// the running sum, its flag and the result valid signal.
// Depends on mlhe_pkg.
`default_nettype none

module mobility_law_huber_error_top
   import mlhe_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   // sample channel
   input  wire                req_valid,
   output logic               req_stall,
   input  req_data_type       req_data,
   // result channel
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rsp_data_type       rsp_data,
   // configuration channel
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [2:0]         csr_index,
   input  wire  [31:0]        csr_wdata
);

   localparam logic [31:0] MOB_RESET   = 32'(64'd1 << FRAC_BITS);
   localparam logic [30:0] HUBER_RESET = 31'(64'(HUBER_DEFAULT_INT) << FRAC_BITS);
   localparam logic [4:0]  SQRT_LAST   = 5'(SQRT_STEPS - 1);

   // Configuration registers
   logic signed [31:0] mob_ff,   mob_in;
   logic signed [31:0] alpha_ff, alpha_in;
   logic signed [31:0] beta_ff,  beta_in;
   logic signed [31:0] shear_ff, shear_in;
   logic        [30:0] huber_ff, huber_in;

   // Control state
   state_type    state_ff, state_in;
   ctrl_type     ctrl;
   logic         half_ff, half_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [62:0]  acc_ff, acc_in;
   logic         sat_flag_ff, sat_flag_in;

   // Datapath registers
   req_data_type       smp_ff, smp_in;
   logic [63:0]        mul_a_ff, mul_a_in;
   logic [31:0]        mul_b_ff, mul_b_in;
   logic [95:0]        prod_ff, prod_in;
   logic [63:0]        rad_ff, rad_in;
   logic [63:0]        sq_res_ff, sq_res_in;
   logic [63:0]        sq_bit_ff, sq_bit_in;
   logic signed [63:0] diff_ff, diff_in;
   logic signed [31:0] fitted_ff, fitted_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   // Datapath intermediates
   logic               req_accept;
   logic               out_free;
   logic [31:0]        mul_lhs;
   logic [63:0]        pp;
   logic [95:0]        prod_shf;
   logic [95:0]        prod_sh8;
   logic [63:0]        prod_satf;
   logic [63:0]        prod_sat8;
   logic [64:0]        rad_sum;
   logic [63:0]        sq_trial;
   logic [63:0]        tmag;
   logic signed [63:0] term;
   logic               v_neg;
   logic               v_big;
   logic signed [32:0] resid;
   logic [32:0]        resid_mag;
   logic [31:0]        r_abs;
   logic [64:0]        acc_tot;
   logic               acc_over;
   logic [62:0]        sum_val;
   logic               flag_val;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_AA;
         ST_MUL_AA:  if (half_ff) state_in = ST_LD_RAD;
         ST_LD_RAD:  state_in = ST_MUL_RAD;
         ST_MUL_RAD: if (half_ff) state_in = ST_SH_RAD;
         ST_SH_RAD:  state_in = ST_MUL_BB;
         ST_MUL_BB:  if (half_ff) state_in = ST_ADD_RAD;
         ST_ADD_RAD: state_in = ST_SQRT;
         ST_SQRT:    if (cnt_ff == SQRT_LAST) state_in = ST_LD_SH;
         ST_LD_SH:   state_in = ST_MUL_SH;
         ST_MUL_SH:  if (half_ff) state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_LD_V;
         ST_LD_V:    state_in = ST_MUL_V;
         ST_MUL_V:   if (half_ff) state_in = ST_FIT;
         ST_FIT:     state_in = ST_RES;
         ST_RES:     state_in = ST_MUL_L;
         ST_MUL_L:   if (half_ff) state_in = ST_LD_W;
         ST_LD_W:    state_in = ST_MUL_W;
         ST_MUL_W:   if (half_ff) state_in = ST_ACC;
         ST_ACC:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Decode enables from the state
   always_comb begin
      ctrl.mul_en  = 1'b0;
      ctrl.sqrt_en = 1'b0;
      ctrl.busy    = 1'b1;
      case (state_ff)
         ST_IDLE:    ctrl.busy = 1'b0;
         ST_MUL_AA,
         ST_MUL_RAD,
         ST_MUL_BB,
         ST_MUL_SH,
         ST_MUL_V,
         ST_MUL_L,
         ST_MUL_W:   ctrl.mul_en = 1'b1;
         ST_SQRT:    ctrl.sqrt_en = 1'b1;
         default:    ctrl.busy = 1'b1;
      endcase
   end

   assign req_stall = ctrl.busy;

   // Shared multiplier: low half of the wide operand first, then the high half
   assign mul_lhs = half_ff ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign pp      = {32'b0, mul_lhs} * {32'b0, mul_b_ff};

   // Product post-processing: shift and saturate to 64 bits
   assign prod_shf  = prod_ff >> FRAC_BITS;
   assign prod_sh8  = prod_ff >> 8;
   assign prod_satf = (|prod_shf[95:64]) ? {64{1'b1}} : prod_shf[63:0];
   assign prod_sat8 = (|prod_sh8[95:64]) ? {64{1'b1}} : prod_sh8[63:0];

   // Radicand add and square root trial
   assign rad_sum  = {1'b0, rad_ff} + {1'b0, prod_ff[63:0]};
   assign sq_trial = sq_res_ff + sq_bit_ff;

   // Shear term with the sign of the shear coefficient
   assign tmag = prod_ff[63:0] >> FRAC_BITS;
   assign term = shear_ff[31] ? -$signed(tmag) : $signed(tmag);

   // Fitted velocity clamp
   assign v_neg = diff_ff[63] ^ mob_ff[31];
   assign v_big = |prod_shf[95:31];

   // Absolute residual
   assign resid     = 33'(fitted_ff) - 33'(smp_ff.measured_velocity);
   assign resid_mag = resid[32] ? 33'(-resid) : 33'(resid);
   assign r_abs     = resid_mag[31:0];

   // Saturating accumulation
   assign acc_tot  = {1'b0, prod_sat8} + {2'b0, acc_ff};
   assign acc_over = |acc_tot[64:63];
   assign sum_val  = acc_over ? SUM_MAX : acc_tot[62:0];
   assign flag_val = sat_flag_ff | acc_over;

   // Datapath next values
   always_comb begin
      smp_in       = smp_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      diff_in      = diff_ff;
      fitted_in    = fitted_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      acc_in       = acc_ff;
      sat_flag_in  = sat_flag_ff;

      if (ctrl.mul_en) begin
         prod_in = half_ff ? (prod_ff + {pp, 32'b0}) : {32'b0, pp};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               smp_in   = req_data;
               mul_a_in = {32'b0, mag32(alpha_ff)};
               mul_b_in = mag32(alpha_ff);
            end
         end
         ST_LD_RAD: begin
            mul_a_in = prod_ff[63:0];
            mul_b_in = smp_ff.density;
         end
         ST_SH_RAD: begin
            rad_in   = prod_satf;
            mul_a_in = {32'b0, mag32(beta_ff)};
            mul_b_in = mag32(beta_ff);
         end
         ST_ADD_RAD: begin
            rad_in    = rad_sum[64] ? {64{1'b1}} : rad_sum[63:0];
            sq_res_in = '0;
            sq_bit_in = SQRT_BIT_INIT;
         end
         ST_SQRT: begin
            if (rad_ff >= sq_trial) begin
               rad_in    = rad_ff - sq_trial;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         ST_LD_SH: begin
            mul_a_in = {32'b0, sq_res_ff[31:0]};
            mul_b_in = mag32(shear_ff);
         end
         ST_DIFF: begin
            diff_in = 64'(smp_ff.stress) - term;
         end
         ST_LD_V: begin
            mul_a_in = diff_ff[63] ? 64'(-diff_ff) : 64'(diff_ff);
            mul_b_in = mag32(mob_ff);
         end
         ST_FIT: begin
            if (v_neg) begin
               fitted_in = v_big ? 32'sh8000_0000 : -$signed(prod_shf[31:0]);
            end else begin
               fitted_in = v_big ? 32'sh7FFF_FFFF : $signed(prod_shf[31:0]);
            end
         end
         ST_RES: begin
            // Quadratic branch below the threshold, linear branch at or above it
            if (r_abs < {1'b0, huber_ff}) begin
               mul_a_in = {32'b0, r_abs};
               mul_b_in = r_abs;
            end else begin
               mul_a_in = {31'b0, r_abs, 1'b0} - {33'b0, huber_ff};
               mul_b_in = {1'b0, huber_ff};
            end
         end
         ST_LD_W: begin
            mul_a_in = prod_ff[63:0] >> FRAC_BITS;
            mul_b_in = {16'b0, smp_ff.sample_weight};
         end
         ST_ACC: begin
            if (out_free) begin
               rsp_data_in.fitted_velocity = fitted_ff;
               rsp_data_in.error_sum       = sum_val;
               rsp_data_in.sum_final       = smp_ff.last_sample;
               rsp_data_in.sum_saturated   = flag_val;
               rsp_valid_in                = 1'b1;
               acc_in      = smp_ff.last_sample ? '0 : sum_val;
               sat_flag_in = smp_ff.last_sample ? 1'b0 : flag_val;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      mob_in   = mob_ff;
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      shear_in = shear_ff;
      huber_in = huber_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOBILITY_BURGERS: mob_in   = $signed(csr_wdata);
            CSR_ALPHA_COEFF:      alpha_in = $signed(csr_wdata);
            CSR_BETA_COEFF:       beta_in  = $signed(csr_wdata);
            CSR_SHEAR_BURGERS:    shear_in = $signed(csr_wdata);
            CSR_HUBER_THRESHOLD:  huber_in = csr_wdata[30:0];
            default:              huber_in = huber_ff;
         endcase
      end
   end

   // Step counters
   assign half_in = ctrl.mul_en ? ~half_ff : 1'b0;
   assign cnt_in  = ctrl.sqrt_en ? cnt_ff + 5'd1 : '0;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         half_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         sat_flag_ff  <= 1'b0;
         mob_ff       <= $signed(MOB_RESET);
         alpha_ff     <= '0;
         beta_ff      <= '0;
         shear_ff     <= '0;
         huber_ff     <= HUBER_RESET;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         sat_flag_ff  <= sat_flag_in;
         mob_ff       <= mob_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         shear_ff     <= shear_in;
         huber_ff     <= huber_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= prod_in;
      rad_ff      <= rad_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      diff_ff     <= diff_in;
      fitted_ff   <= fitted_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A new result is only raised from the accumulate step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACC))
      else $error("result raised outside the accumulate step");

   // An accepted sample starts the sequence
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MUL_AA)
      else $error("accepted sample did not start the sequencer");

   // The square root moves on after its last step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && cnt_ff == SQRT_LAST) |=> state_ff == ST_LD_SH)
      else $error("square root step count broken");

   // A saturated set always reports the saturated sum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.sum_saturated) |-> rsp_data_ff.error_sum == SUM_MAX)
      else $error("saturated flag without saturated sum");

   // The running sum clears after a last sample
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && out_free && smp_ff.last_sample)
         |=> (acc_ff == '0 && !sat_flag_ff))
      else $error("running sum not cleared after last sample");

endmodule

`default_nettype wire
